// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; take in by include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also checks across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/cfp_pkg.sv =====
// Package of the colon header fragment parser: types, codes, limits, helpers.
// No dependencies; compile first.
`default_nettype none

package cfp_pkg;

    localparam int MAX_LINE_DEF = 1250;
    localparam int MAX_DATA_DEF = 1000;
    localparam int MAX_NAME_DEF = 49;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;
    localparam logic [9:0] SIZE_SAT   = 10'd1023;
    localparam logic [5:0] NAME_SAT   = 6'd63;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [1:0] FIELD_TOTAL = 2'd0;
    localparam logic [1:0] FIELD_FRAG  = 2'd1;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_DIGIT    = 3'd1,
        OP_NONDIGIT = 3'd2,
        OP_HEADER   = 3'd3,
        OP_NAME     = 3'd4,
        OP_DATA     = 3'd5
    } t_op;

    typedef struct packed {
        logic       clear;
        t_op        op;
        logic [1:0] field;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] total;
        logic [15:0] frag;
        logic [9:0]  size;
        logic [7:0]  value;
        logic        last;
        logic        name_long;
        logic        clamped;
    } t_result;

    function automatic logic [15:0] acc16(input logic [15:0] acc, input logic [3:0] digit);
        logic [19:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, digit};
        return (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [9:0] acc10(input logic [9:0] acc, input logic [3:0] digit);
        logic [13:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {10'b0, digit};
        return (v > {4'b0, SIZE_SAT}) ? SIZE_SAT : v[9:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/colon_header_fragment_parser_unit.sv =====
// Top level of the colon header fragment parser: front end, command queue, back end,
// result queue. Depends on cfp_pkg, cfp_fifo, cfp_front, cfp_back.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+------------------------------------
//   input     | in        | push / full          | byte_value, start_of_packet
//   result    | out       | pop / empty          | result_kind ... size_clamped
//
// One byte is taken every cycle while full is low; each result passes the command queue,
// then the result queue. The back end runs one command a cycle unless the result queue
// is full. A stalled result side fills the result queue, then the four-entry command
// queue, and only then raises full. Synchronous reset clears both queues and all parse state.
`default_nettype none

module colon_header_fragment_parser_unit
    import cfp_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF,
    parameter int MAX_DATA = MAX_DATA_DEF,
    parameter int MAX_NAME = MAX_NAME_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_start_of_packet,
    output logic             empty,
    input  wire logic        pop,
    output logic      [1:0]  o_result_kind,
    output logic      [15:0] o_total_fragments,
    output logic      [15:0] o_fragment_number,
    output logic      [9:0]  o_data_size,
    output logic      [7:0]  o_out_byte,
    output logic             o_last_of_data,
    output logic             o_name_too_long,
    output logic             o_size_clamped
);

    logic    accept;
    logic    cmd_push, cmd_pop, cmd_empty;
    t_cmd    cmd_in, cmd_out;
    logic    res_push, res_full;
    t_result res_in, res_out;

    assign accept = push && !full;

    cfp_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_byte_value     (i_byte_value),
        .i_start_of_packet(i_start_of_packet),
        .o_cmd_push       (cmd_push),
        .o_cmd            (cmd_in)
    );

    cfp_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .i_pop  (cmd_pop),
        .o_data (cmd_out),
        .o_full (full),
        .o_empty(cmd_empty)
    );

    cfp_back #(
        .MAX_DATA(MAX_DATA),
        .MAX_NAME(MAX_NAME)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(!cmd_empty),
        .i_cmd      (cmd_out),
        .o_cmd_pop  (cmd_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    cfp_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .i_pop  (pop),
        .o_data (res_out),
        .o_full (res_full),
        .o_empty(empty)
    );

    assign o_result_kind     = res_out.kind;
    assign o_total_fragments = res_out.total;
    assign o_fragment_number = res_out.frag;
    assign o_data_size       = res_out.size;
    assign o_out_byte        = res_out.value;
    assign o_last_of_data    = res_out.last;
    assign o_name_too_long   = res_out.name_long;
    assign o_size_clamped    = res_out.clamped;

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
// No package dependencies.
`default_nettype none

module cfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_front.sv =====
// Front end: tracks line position and colon count, classifies each byte into a command.
// Depends on cfp_pkg.
`default_nettype none

module cfp_front
    import cfp_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_start_of_packet,
    output logic            o_cmd_push,
    output t_cmd            o_cmd
);

    localparam int PW = $clog2(MAX_LINE + 1);

    logic [PW-1:0] r_pos, n_pos, pos;
    logic [2:0]    r_cc, n_cc, cc;
    logic          is_digit;

    assign pos      = i_start_of_packet ? '0 : r_pos;
    assign cc       = i_start_of_packet ? '0 : r_cc;
    assign is_digit = (i_byte_value >= DIGIT_LO) && (i_byte_value <= DIGIT_HI);

    always_comb begin
        n_pos       = r_pos;
        n_cc        = r_cc;
        o_cmd_push  = 1'b0;
        o_cmd.clear = i_start_of_packet;
        o_cmd.op    = OP_NOP;
        o_cmd.field = cc[1:0];
        o_cmd.value = i_byte_value;
        // bytes past the line limit leave the state alone and queue nothing
        if (i_accept && (pos < PW'(MAX_LINE))) begin
            n_pos      = pos + 1'b1;
            n_cc       = cc;
            o_cmd_push = 1'b1;
            if (cc >= 3'd4) begin
                o_cmd.op = OP_DATA;
            end else if (i_byte_value == COLON_CHAR) begin
                n_cc     = cc + 1'b1;
                o_cmd.op = (cc == 3'd3) ? OP_HEADER : OP_NOP;
            end else if (cc == 3'd3) begin
                o_cmd.op = OP_NAME;
            end else begin
                o_cmd.op = is_digit ? OP_DIGIT : OP_NONDIGIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cc  <= '0;
        end else begin
            r_pos <= n_pos;
            r_cc  <= n_cc;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_back.sv =====
// Back end: runs queued commands, keeps the numeric fields and counters, builds results.
// Depends on cfp_pkg.
`default_nettype none

module cfp_back
    import cfp_pkg::*;
#(
    parameter int MAX_DATA = MAX_DATA_DEF,
    parameter int MAX_NAME = MAX_NAME_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_result   o_res
);

    logic [15:0] r_tot, n_tot, tot;
    logic [15:0] r_frg, n_frg, frg;
    logic [9:0]  r_sz,  n_sz,  sz;
    logic [2:0]  r_frz, n_frz, frz;
    logic [5:0]  r_nl,  n_nl,  nl;
    logic [9:0]  r_rem, n_rem, rem;
    logic [9:0]  hdr_size;
    logic        hdr_clamped;

    assign o_cmd_pop = i_cmd_valid && !i_res_full;

    // start of packet wipes the parse state ahead of this command
    assign tot = i_cmd.clear ? '0 : r_tot;
    assign frg = i_cmd.clear ? '0 : r_frg;
    assign sz  = i_cmd.clear ? '0 : r_sz;
    assign frz = i_cmd.clear ? '0 : r_frz;
    assign nl  = i_cmd.clear ? '0 : r_nl;
    assign rem = i_cmd.clear ? '0 : r_rem;

    assign hdr_clamped = (sz > 10'(MAX_DATA));
    assign hdr_size    = hdr_clamped ? 10'(MAX_DATA) : sz;

    always_comb begin
        n_tot      = r_tot;
        n_frg      = r_frg;
        n_sz       = r_sz;
        n_frz      = r_frz;
        n_nl       = r_nl;
        n_rem      = r_rem;
        o_res      = '0;
        o_res_push = 1'b0;
        if (o_cmd_pop) begin
            n_tot = tot;
            n_frg = frg;
            n_sz  = sz;
            n_frz = frz;
            n_nl  = nl;
            n_rem = rem;
            unique case (i_cmd.op)
                OP_DIGIT: begin
                    if (!frz[i_cmd.field]) begin
                        case (i_cmd.field)
                            FIELD_TOTAL: n_tot = acc16(tot, i_cmd.value[3:0]);
                            FIELD_FRAG:  n_frg = acc16(frg, i_cmd.value[3:0]);
                            default:     n_sz  = acc10(sz, i_cmd.value[3:0]);
                        endcase
                    end
                end
                OP_NONDIGIT: begin
                    n_frz[i_cmd.field] = 1'b1;
                end
                OP_HEADER: begin
                    n_rem         = hdr_size;
                    o_res_push    = 1'b1;
                    o_res.kind    = KIND_HEADER;
                    o_res.total   = tot;
                    o_res.frag    = frg;
                    o_res.size    = hdr_size;
                    o_res.last    = (hdr_size == '0);
                    o_res.clamped = hdr_clamped;
                end
                OP_NAME: begin
                    o_res_push      = 1'b1;
                    o_res.kind      = KIND_NAME;
                    o_res.value     = i_cmd.value;
                    o_res.name_long = (nl >= 6'(MAX_NAME));
                    if (nl != NAME_SAT) begin
                        n_nl = nl + 1'b1;
                    end
                end
                OP_DATA: begin
                    // drop bytes once the stated size is used up
                    if (rem != '0) begin
                        n_rem       = rem - 1'b1;
                        o_res_push  = 1'b1;
                        o_res.kind  = KIND_DATA;
                        o_res.value = i_cmd.value;
                        o_res.last  = (rem == 10'd1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= '0;
            r_frg <= '0;
            r_sz  <= '0;
            r_frz <= '0;
            r_nl  <= '0;
            r_rem <= '0;
        end else begin
            r_tot <= n_tot;
            r_frg <= n_frg;
            r_sz  <= n_sz;
            r_frz <= n_frz;
            r_nl  <= n_nl;
            r_rem <= n_rem;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_checker.sv =====
// Port-level checks of the colon header fragment parser, bound to the top level.
// Depends on cfp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cfp_checker
    import cfp_pkg::*;
#(
    parameter int MAX_DATA = MAX_DATA_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  o_result_kind,
    input wire logic [9:0]  o_data_size,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_last_of_data,
    input wire logic        o_size_clamped
);

    logic is_hdr;
    assign is_hdr = !empty && (o_result_kind == KIND_HEADER);

    // the queue comes out of reset empty
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, empty)

    // a header carries the size after clamping and marks last only for an empty body
    `ASSERT_IMPL(a_hdr_size, i_clk, i_rst_n, is_hdr,
                 (o_data_size <= 10'(MAX_DATA)) && (o_last_of_data == (o_data_size == '0)))

    // clamp flag and last mark never ride on a name byte
    `ASSERT_IMPL(a_name_flags, i_clk, i_rst_n, !empty && (o_result_kind == KIND_NAME),
                 !o_last_of_data && !o_size_clamped)

    // an untaken result stays put
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out_byte))

endmodule

bind colon_header_fragment_parser_unit cfp_checker #(
    .MAX_DATA(MAX_DATA)
) u_cfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_result_kind (o_result_kind),
    .o_data_size   (o_data_size),
    .o_out_byte    (o_out_byte),
    .o_last_of_data(o_last_of_data),
    .o_size_clamped(o_size_clamped)
);

`default_nettype wire

// ===== bench/colon_header_fragment_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for colon_header_fragment_parser_unit: drives datagram bytes, predicts
// every name, header and data beat, and checks them in order. Depends on cfp_pkg and the RTL.

module colon_header_fragment_parser_unit_tb;
    import cfp_pkg::*;

    localparam int RANDOM_BEATS = 1850;

    // Tracks the parse of the current datagram and holds the beats it should produce.
    class header_parse_scoreboard;
        t_result     expected_beats_q[$];
        int unsigned mismatches;
        int unsigned name_beats, long_name_beats, header_beats, clamped_headers;
        int unsigned data_beats, last_beats;

        logic [2:0]  colons;
        int unsigned position;
        logic [15:0] total_acc;
        logic [15:0] frag_acc;
        logic [9:0]  size_acc;
        logic [2:0]  frozen;
        logic [5:0]  name_len;
        logic [9:0]  remaining;

        function new();
            restart();
        endfunction

        function void restart();
            colons    = '0;
            position  = 0;
            total_acc = '0;
            frag_acc  = '0;
            size_acc  = '0;
            frozen    = '0;
            name_len  = '0;
            remaining = '0;
        endfunction

        function int unsigned append_digit(int unsigned acc, int unsigned digit,
                                           int unsigned ceiling);
            int unsigned v;
            v = acc * 10 + digit;
            return (v > ceiling) ? ceiling : v;
        endfunction

        function void predict_byte(logic [7:0] b, logic sop);
            t_result     r;
            int unsigned eff_size;
            r = '0;
            if (sop) restart();
            if (position >= MAX_LINE_DEF) return;
            position++;
            if (colons >= 3'd4) begin
                if (remaining == 0) return;
                remaining--;
                r.kind  = KIND_DATA;
                r.value = b;
                r.last  = (remaining == 0);
                expected_beats_q.push_back(r);
                return;
            end
            if (b == COLON_CHAR) begin
                colons++;
                if (colons < 3'd4) return;
                eff_size = size_acc;
                if (eff_size > MAX_DATA_DEF) begin
                    eff_size  = MAX_DATA_DEF;
                    r.clamped = 1'b1;
                end
                remaining = 10'(eff_size);
                r.kind    = KIND_HEADER;
                r.total   = total_acc;
                r.frag    = frag_acc;
                r.size    = 10'(eff_size);
                r.last    = (eff_size == 0);
                expected_beats_q.push_back(r);
                return;
            end
            if (colons == 3'd3) begin
                r.kind      = KIND_NAME;
                r.value     = b;
                r.name_long = (name_len >= MAX_NAME_DEF);
                if (name_len < NAME_SAT) name_len++;
                expected_beats_q.push_back(r);
                return;
            end
            // numeric fields: a non-digit freezes the field for the rest of the datagram
            if (frozen[colons]) return;
            if (b < DIGIT_LO || b > DIGIT_HI) begin
                frozen[colons] = 1'b1;
                return;
            end
            case (colons)
                3'd0: total_acc = 16'(append_digit(total_acc, b - DIGIT_LO, 65535));
                3'd1: frag_acc  = 16'(append_digit(frag_acc, b - DIGIT_LO, 65535));
                default: size_acc = 10'(append_digit(size_acc, b - DIGIT_LO, SIZE_SAT));
            endcase
        endfunction

        function string describe(t_result r);
            return $sformatf({"kind %0d total %0d frag %0d size %0d byte %02h",
                              " last %0b long %0b clamp %0b"},
                             r.kind, r.total, r.frag, r.size, r.value, r.last, r.name_long,
                             r.clamped);
        endfunction

        function void check_result(t_result got);
            t_result want;
            string   bad;
            case (got.kind)
                KIND_NAME: begin
                    name_beats++;
                    if (got.name_long) long_name_beats++;
                end
                KIND_HEADER: begin
                    header_beats++;
                    if (got.clamped) clamped_headers++;
                end
                default: begin
                    data_beats++;
                    if (got.last) last_beats++;
                end
            endcase
            if (expected_beats_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: beat with nothing expected: %s", $time, describe(got));
                return;
            end
            want = expected_beats_q.pop_front();
            bad  = "";
            if (got.kind      !== want.kind)      bad = {bad, " kind"};
            if (got.total     !== want.total)     bad = {bad, " total"};
            if (got.frag      !== want.frag)      bad = {bad, " frag"};
            if (got.size      !== want.size)      bad = {bad, " size"};
            if (got.value     !== want.value)     bad = {bad, " byte"};
            if (got.last      !== want.last)      bad = {bad, " last"};
            if (got.name_long !== want.name_long) bad = {bad, " name_long"};
            if (got.clamped   !== want.clamped)   bad = {bad, " clamped"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch in%s", $time, bad);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function int unsigned pending();
            return expected_beats_q.size();
        endfunction
    endclass

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        push              = 1'b0;
    logic        pop               = 1'b0;
    logic [7:0]  i_byte_value      = '0;
    logic        i_start_of_packet = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_result_kind;
    logic [15:0] o_total_fragments;
    logic [15:0] o_fragment_number;
    logic [9:0]  o_data_size;
    logic [7:0]  o_out_byte;
    logic        o_last_of_data;
    logic        o_name_too_long;
    logic        o_size_clamped;

    header_parse_scoreboard sb = new();

    logic [7:0]  datagram_q[$];
    bit          quiet = 1'b0;
    int unsigned beats_sent = 0;
    int unsigned datagrams_sent = 0;

    colon_header_fragment_parser_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_byte_value      (i_byte_value),
        .i_start_of_packet (i_start_of_packet),
        .empty             (empty),
        .pop               (pop),
        .o_result_kind     (o_result_kind),
        .o_total_fragments (o_total_fragments),
        .o_fragment_number (o_fragment_number),
        .o_data_size       (o_data_size),
        .o_out_byte        (o_out_byte),
        .o_last_of_data    (o_last_of_data),
        .o_name_too_long   (o_name_too_long),
        .o_size_clamped    (o_size_clamped)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function void put_text(string s);
        foreach (s[i]) datagram_q.push_back(s[i]);
    endfunction

    function logic [7:0] any_non_colon();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == COLON_CHAR);
        return b;
    endfunction

    // Append a numeric field worth v, decorated at random; return v.
    function int unsigned put_numeric(int unsigned v);
        int unsigned style;
        logic [7:0]  b;
        style = $urandom_range(0, 5);
        if (v == 0 && style == 0) return 0;
        if (style == 1) repeat ($urandom_range(1, 3)) datagram_q.push_back(DIGIT_LO);
        put_text($sformatf("%0d", v));
        if (style == 2) begin
            do b = any_non_colon(); while (b >= DIGIT_LO && b <= DIGIT_HI);
            datagram_q.push_back(b);
            repeat ($urandom_range(0, 3)) datagram_q.push_back(8'(DIGIT_LO + $urandom_range(0, 9)));
        end
        return v;
    endfunction

    function int unsigned pick_count();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(65530, 999999)
                                            : $urandom_range(0, 300);
    endfunction

    function void build_datagram(bit long_form);
        int unsigned size, eff, name_bytes, data_bytes;
        datagram_q.delete();
        void'(put_numeric(pick_count()));
        datagram_q.push_back(COLON_CHAR);
        void'(put_numeric(pick_count()));
        datagram_q.push_back(COLON_CHAR);
        if (long_form) size = 1001;
        else case ($urandom_range(0, 19))
            0:       size = $urandom_range(1000, 1002);
            1:       size = $urandom_range(1003, 99999);
            2:       size = 1023;
            default: size = $urandom_range(0, 12);
        endcase
        size = put_numeric(size);
        datagram_q.push_back(COLON_CHAR);
        if (long_form) name_bytes = 300;
        else name_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(45, 60)
                                                      : $urandom_range(0, 6);
        repeat (name_bytes) datagram_q.push_back(any_non_colon());
        datagram_q.push_back(COLON_CHAR);
        eff = (size > MAX_DATA_DEF) ? MAX_DATA_DEF : size;
        // long form runs past the line limit, so its data never gets the last mark
        if (long_form) data_bytes = MAX_DATA_DEF;
        else if (eff > 40) data_bytes = $urandom_range(0, 30);
        else if ($urandom_range(0, 4) == 0) data_bytes = $urandom_range(0, eff);
        else data_bytes = eff + $urandom_range(0, 3);
        repeat (data_bytes)
            datagram_q.push_back(($urandom_range(0, 5) == 0) ? COLON_CHAR
                                                             : 8'($urandom_range(0, 255)));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic sop);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        push              <= 1'b1;
        i_byte_value      <= b;
        i_start_of_packet <= sop;
        do @(posedge i_clk); while (full);
        sb.predict_byte(b, sop);
        beats_sent++;
    endtask

    task automatic send_datagram(input bit with_sop);
        foreach (datagram_q[i]) send_byte(datagram_q[i], with_sop && i == 0);
        datagrams_sent++;
    endtask

    // Hold the sender off until every predicted beat has come out.
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        int unsigned stall_left;
        t_result     got;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got.kind      = o_result_kind;
                got.total     = o_total_fragments;
                got.frag      = o_fragment_number;
                got.size      = o_data_size;
                got.value     = o_out_byte;
                got.last      = o_last_of_data;
                got.name_long = o_name_too_long;
                got.clamped   = o_size_clamped;
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned random_start, done, pick;
        bit          long_sent, paused;
        long_sent = 1'b0;
        paused    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no start flag after reset, NUL name byte, colon as the only data byte
        datagram_q.delete();
        put_text("7:2:1:");
        datagram_q.push_back(8'h00);
        put_text("::");
        send_datagram(1'b0);
        // all fields empty: zero-size header, then a trailing byte to drop
        datagram_q.delete();
        put_text("::::A");
        send_datagram(1'b1);
        // saturated total, frozen empty fragment, clamped size
        datagram_q.delete();
        put_text("70000:a:2000::");
        send_datagram(1'b1);
        wait_drained();

        random_start = beats_sent;
        done         = 0;
        while (done < RANDOM_BEATS) begin
            quiet = (done >= RANDOM_BEATS - 250);
            if (!paused && done >= RANDOM_BEATS - 300) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (!long_sent && done >= 200) begin
                build_datagram(1'b1);
                long_sent = 1'b1;
            end else if (pick == 0) begin
                datagram_q.delete();
                repeat ($urandom_range(1, 20))
                    case ($urandom_range(0, 3))
                        0:       datagram_q.push_back(COLON_CHAR);
                        1:       datagram_q.push_back(8'(DIGIT_LO + $urandom_range(0, 9)));
                        default: datagram_q.push_back(8'($urandom_range(0, 255)));
                    endcase
            end else begin
                build_datagram(1'b0);
                // cut the datagram short so the next start flag lands mid-parse
                if (pick == 1 && datagram_q.size() > 1)
                    datagram_q = datagram_q[0 : $urandom_range(0, datagram_q.size() - 2)];
            end
            send_datagram($urandom_range(0, 19) != 0);
            done = beats_sent - random_start;
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d bytes in %0d datagrams; checked %0d headers (%0d clamped),",
                 beats_sent, datagrams_sent, sb.header_beats, sb.clamped_headers);
        $display("%0d name bytes (%0d over limit), %0d data bytes (%0d last), %0d mismatches.",
                 sb.name_beats, sb.long_name_beats, sb.data_beats, sb.last_beats,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
